@@ src/tkbd_pkg.sv @@
// Package with the shared types, byte codes and key codes of the terminal key byte decoder.
`timescale 1ns / 1ps

package tkbd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2,
    MODE_UTF8 = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KEY_TEXT  = 4'd0,
    KEY_ESC   = 4'd1,
    KEY_UP    = 4'd2,
    KEY_DOWN  = 4'd3,
    KEY_RIGHT = 4'd4,
    KEY_LEFT  = 4'd5,
    KEY_HOME  = 4'd6,
    KEY_END   = 4'd7,
    KEY_PGUP  = 4'd8,
    KEY_PGDN  = 4'd9,
    KEY_F1    = 4'd10,
    KEY_F2    = 4'd11,
    KEY_BKSP  = 4'd12,
    KEY_ENTER = 4'd13,
    KEY_TAB   = 4'd14
  } key_t;

  localparam logic [7:0] BYTE_CTRL_A = 8'h01;
  localparam logic [7:0] BYTE_CTRL_C = 8'h03;
  localparam logic [7:0] BYTE_CTRL_D = 8'h04;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_UPPER_A = 8'h41;
  localparam logic [7:0] BYTE_UPPER_B = 8'h42;
  localparam logic [7:0] BYTE_UPPER_C = 8'h43;
  localparam logic [7:0] BYTE_UPPER_D = 8'h44;
  localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
  localparam logic [7:0] BYTE_DIGIT_1 = 8'h31;
  localparam logic [7:0] BYTE_DIGIT_2 = 8'h32;
  localparam logic [7:0] BYTE_DIGIT_4 = 8'h34;
  localparam logic [7:0] BYTE_DIGIT_5 = 8'h35;
  localparam logic [7:0] BYTE_DIGIT_6 = 8'h36;

  typedef struct packed {
    key_t        key;
    logic        ctrl;
    logic [31:0] bytes;
    logic [2:0]  len;
  } ev_t;

  localparam ev_t EV_NONE = '{key: KEY_TEXT, ctrl: 1'b0, bytes: 32'h0, len: 3'd0};

  typedef struct packed {
    mode_t       mode;
    logic [23:0] utf8_bytes;
    logic [1:0]  utf8_count;
    logic [2:0]  utf8_need;
    logic [15:0] csi_body;
    logic [1:0]  csi_len;
  } pstate_t;

  localparam pstate_t PSTATE_RESET = '{mode: MODE_IDLE, utf8_bytes: 24'h0, utf8_count: 2'd0,
                                       utf8_need: 3'd0, csi_body: 16'h0, csi_len: 2'd0};

  typedef struct packed {
    logic [1:0] count;
    ev_t        ev0;
    ev_t        ev1;
    pstate_t    nxt;
  } dec_t;

endpackage

@@ src/tkbd_decode.sv @@
// Combinational decode of one byte against the parser state into up to two key events.
`timescale 1ns / 1ps

module tkbd_decode (
  input  tkbd_pkg::pstate_t st,
  input  logic [7:0]        c,
  input  logic              last,
  output tkbd_pkg::dec_t    dec
);

  typedef struct packed {
    logic            ev_valid;
    tkbd_pkg::ev_t   ev;
    tkbd_pkg::mode_t mode;
    logic            lead;
    logic [2:0]      need;
  } idle_t;

  function automatic idle_t idle_byte(input logic [7:0] b, input logic fin);
    idle_t r;
    r          = '0;
    r.ev       = tkbd_pkg::EV_NONE;
    r.mode     = tkbd_pkg::MODE_IDLE;
    if (b == tkbd_pkg::BYTE_ESC) begin
      if (fin) begin
        r.ev_valid = 1'b1;
        r.ev.key   = tkbd_pkg::KEY_ESC;
      end else begin
        r.mode = tkbd_pkg::MODE_ESC;
      end
    end else if (!b[7]) begin
      r.ev_valid = 1'b1;
      unique case (b) inside
        tkbd_pkg::BYTE_CTRL_A, tkbd_pkg::BYTE_CTRL_C, tkbd_pkg::BYTE_CTRL_D: r.ev.ctrl = 1'b1;
        tkbd_pkg::BYTE_BS, tkbd_pkg::BYTE_DEL: r.ev.key = tkbd_pkg::KEY_BKSP;
        tkbd_pkg::BYTE_LF, tkbd_pkg::BYTE_CR:  r.ev.key = tkbd_pkg::KEY_ENTER;
        tkbd_pkg::BYTE_TAB:                    r.ev.key = tkbd_pkg::KEY_TAB;
        default: begin
          r.ev.bytes = {24'h0, b};
          r.ev.len   = 3'd1;
        end
      endcase
    end else if (b[7:5] == 3'b110) begin
      r.lead = 1'b1;
      r.need = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      r.lead = 1'b1;
      r.need = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      r.lead = 1'b1;
      r.need = 3'd4;
    end
    if (r.lead) begin
      r.mode = tkbd_pkg::MODE_UTF8;
    end
    return r;
  endfunction

  function automatic tkbd_pkg::key_t csi_key(input logic [7:0] t, input logic [1:0] len,
                                              input logic [7:0] b0, input logic [7:0] b1);
    tkbd_pkg::key_t k;
    k = tkbd_pkg::KEY_TEXT;
    if (len == 2'd0) begin
      unique case (t)
        tkbd_pkg::BYTE_UPPER_A: k = tkbd_pkg::KEY_UP;
        tkbd_pkg::BYTE_UPPER_B: k = tkbd_pkg::KEY_DOWN;
        tkbd_pkg::BYTE_UPPER_C: k = tkbd_pkg::KEY_RIGHT;
        tkbd_pkg::BYTE_UPPER_D: k = tkbd_pkg::KEY_LEFT;
        default:                k = tkbd_pkg::KEY_TEXT;
      endcase
    end else if (t == tkbd_pkg::BYTE_TILDE && len == 2'd1) begin
      unique case (b0)
        tkbd_pkg::BYTE_DIGIT_1: k = tkbd_pkg::KEY_HOME;
        tkbd_pkg::BYTE_DIGIT_4: k = tkbd_pkg::KEY_END;
        tkbd_pkg::BYTE_DIGIT_5: k = tkbd_pkg::KEY_PGUP;
        tkbd_pkg::BYTE_DIGIT_6: k = tkbd_pkg::KEY_PGDN;
        default:                k = tkbd_pkg::KEY_TEXT;
      endcase
    end else if (t == tkbd_pkg::BYTE_TILDE && len == 2'd2 && b0 == tkbd_pkg::BYTE_DIGIT_1) begin
      unique case (b1)
        tkbd_pkg::BYTE_DIGIT_1: k = tkbd_pkg::KEY_F1;
        tkbd_pkg::BYTE_DIGIT_2: k = tkbd_pkg::KEY_F2;
        default:                k = tkbd_pkg::KEY_TEXT;
      endcase
    end
    return k;
  endfunction

  idle_t       ir;
  logic        is_term;
  logic [31:0] u_full;
  logic [2:0]  u_cnt_next;

  assign ir         = idle_byte(c, last);
  assign is_term    = (c >= tkbd_pkg::BYTE_UPPER_A && c <= tkbd_pkg::BYTE_UPPER_Z) ||
                      c == tkbd_pkg::BYTE_TILDE;
  assign u_full     = {8'h00, st.utf8_bytes} | ({24'h0, c} << {st.utf8_count, 3'b000});
  assign u_cnt_next = {1'b0, st.utf8_count} + 3'd1;

  always_comb begin
    dec.count = 2'd0;
    dec.ev0   = tkbd_pkg::EV_NONE;
    dec.ev1   = tkbd_pkg::EV_NONE;
    dec.nxt   = st;
    unique case (st.mode)
      tkbd_pkg::MODE_ESC: begin
        dec.ev0.key = tkbd_pkg::KEY_ESC;
        dec.count   = 2'd1;
        if (c == tkbd_pkg::BYTE_LBRACK) begin
          if (last) begin
            dec.count     = 2'd2;
            dec.ev1.bytes = {24'h0, c};
            dec.ev1.len   = 3'd1;
            dec.nxt.mode  = tkbd_pkg::MODE_IDLE;
          end else begin
            dec.nxt.mode     = tkbd_pkg::MODE_CSI;
            dec.nxt.csi_body = 16'h0;
            dec.nxt.csi_len  = 2'd0;
          end
        end else begin
          if (ir.ev_valid) begin
            dec.count = 2'd2;
            dec.ev1   = ir.ev;
          end
          dec.nxt.mode = ir.mode;
          if (ir.lead) begin
            dec.nxt.utf8_bytes = {16'h0, c};
            dec.nxt.utf8_count = 2'd1;
            dec.nxt.utf8_need  = ir.need;
          end
        end
      end
      tkbd_pkg::MODE_CSI: begin
        if (is_term) begin
          dec.count    = 2'd1;
          dec.ev0.key  = csi_key(c, st.csi_len, st.csi_body[7:0], st.csi_body[15:8]);
          dec.nxt.mode = tkbd_pkg::MODE_IDLE;
        end else begin
          if (st.csi_len == 2'd0) begin
            dec.nxt.csi_body[7:0] = c;
          end
          if (st.csi_len == 2'd1) begin
            dec.nxt.csi_body[15:8] = c;
          end
          if (st.csi_len != 2'd3) begin
            dec.nxt.csi_len = st.csi_len + 2'd1;
          end
        end
      end
      tkbd_pkg::MODE_UTF8: begin
        if (u_cnt_next >= st.utf8_need) begin
          dec.count     = 2'd1;
          dec.ev0.bytes = u_full;
          dec.ev0.len   = st.utf8_need;
          dec.nxt.mode  = tkbd_pkg::MODE_IDLE;
        end else begin
          dec.nxt.utf8_bytes = u_full[23:0];
          dec.nxt.utf8_count = u_cnt_next[1:0];
        end
      end
      tkbd_pkg::MODE_IDLE: begin
        if (ir.ev_valid) begin
          dec.count = 2'd1;
          dec.ev0   = ir.ev;
        end
        dec.nxt.mode = ir.mode;
        if (ir.lead) begin
          dec.nxt.utf8_bytes = {16'h0, c};
          dec.nxt.utf8_count = 2'd1;
          dec.nxt.utf8_need  = ir.need;
        end
      end
      default: dec.nxt.mode = tkbd_pkg::MODE_IDLE;
    endcase
  end

endmodule

@@ src/tkbd_out.sv @@
// Result register that holds one key event until the output channel takes it.
`timescale 1ns / 1ps

module tkbd_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tkbd_pkg::ev_t ev,
  input  logic          ev_last,
  input  logic          out_stall,
  output logic          free,
  output logic          out_valid,
  output logic [3:0]    key_code,
  output logic          ctrl_flag,
  output logic [31:0]   text_bytes,
  output logic [2:0]    text_len,
  output logic          last_event
);

  tkbd_pkg::ev_t held;
  logic          held_last;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held      <= ev;
      held_last <= ev_last;
    end
  end

  assign key_code   = held.key;
  assign ctrl_flag  = held.ctrl;
  assign text_bytes = held.bytes;
  assign text_len   = held.len;
  assign last_event = held_last;

endmodule

@@ src/terminal_key_byte_decoder.sv @@
// Top level of the terminal key byte decoder: input register, parser state and event sequencing.
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall  | in_byte, chunk_end
//   output  | out_valid / out_stall| key_code, ctrl_flag, text_bytes, text_len, last_event
//
// An item is registered, decoded against the parser state and its event loaded into the result
// register; one item is taken per cycle unless a stall or a second event holds the input.
// An item that causes two events (a pending escape followed by another key) holds the input
// register until the second event has been loaded.
// Synchronous reset returns the parser to idle and empties both registers.
// A stall on the output holds the result register and, while the input register holds an item
// with an event to load, stalls the input side in the same cycle.
`timescale 1ns / 1ps

module terminal_key_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  key_code,
  output logic        ctrl_flag,
  output logic [31:0] text_bytes,
  output logic [2:0]  text_len,
  output logic        last_event
);

  logic              ireg_valid;
  logic [7:0]        ireg_byte;
  logic              ireg_last;
  logic              phase;
  tkbd_pkg::pstate_t st;
  tkbd_pkg::dec_t    dec;
  logic              free;
  logic              two;
  logic              retire;
  logic              load;
  tkbd_pkg::ev_t     load_ev;
  logic              load_last;

  tkbd_decode u_decode (
    .st   (st),
    .c    (ireg_byte),
    .last (ireg_last),
    .dec  (dec)
  );

  assign two       = dec.count == 2'd2;
  assign retire    = ireg_valid && (dec.count == 2'd0 || (free && (!two || phase)));
  assign load      = ireg_valid && free && dec.count != 2'd0;
  assign load_ev   = phase ? dec.ev1 : dec.ev0;
  assign load_last = !two || phase;
  assign in_stall  = ireg_valid && !retire;

  tkbd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .ev         (load_ev),
    .ev_last    (load_last),
    .out_stall  (out_stall),
    .free       (free),
    .out_valid  (out_valid),
    .key_code   (key_code),
    .ctrl_flag  (ctrl_flag),
    .text_bytes (text_bytes),
    .text_len   (text_len),
    .last_event (last_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
      phase      <= 1'b0;
      st         <= tkbd_pkg::PSTATE_RESET;
    end else begin
      if (!in_stall) begin
        ireg_valid <= in_valid;
      end
      if (retire) begin
        phase <= 1'b0;
        st    <= dec.nxt;
      end else if (load && two) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ireg_byte <= in_byte;
      ireg_last <= chunk_end;
    end
  end

  a_phase_needs_item: assert property (@(posedge clk) disable iff (rst)
    phase |-> ireg_valid && st.mode == tkbd_pkg::MODE_ESC)
    else $error("second event pending without an escape item in the input register");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !retire |=> st == $past(st))
    else $error("parser state changed without retiring an item");

  a_utf8_count: assert property (@(posedge clk) disable iff (rst)
    st.mode == tkbd_pkg::MODE_UTF8 |-> st.utf8_count != 2'd0 &&
                                       {1'b0, st.utf8_count} < st.utf8_need)
    else $error("UTF-8 byte count out of range");

  a_two_then_last: assert property (@(posedge clk) disable iff (rst)
    load && two && !phase |=> phase)
    else $error("first of two events loaded without moving to the second");

endmodule
